// ===== src/iir_df1_pkg.sv =====
// Shared constants, types and microcode table of the direct form one IIR filter.
package iir_df1_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 18;
   localparam int A0_W         = 17;
   localparam int HIST_W       = 32;
   localparam int PROD_W       = COEF_W + HIST_W;
   localparam int ACC_W        = 54;
   localparam int DIV_STEPS    = ACC_W / 2;
   localparam int DCNT_W       = $clog2(DIV_STEPS);
   localparam int COEF_TAPS    = 4;
   localparam int TAP_W        = 2;
   localparam int NUM_TAPS_DEF = 4;
   localparam int DEN_TAPS_DEF = 4;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int PC_W         = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [PC_W-1:0]            pc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_START,
      OP_MUL_FF,
      OP_ACC_ADD,
      OP_FB_INIT,
      OP_MUL_FB,
      OP_ACC_SUB,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_FF_MORE,
      COND_FB_NONE,
      COND_FB_MORE,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      REG_B0,
      REG_B1,
      REG_B2,
      REG_B3,
      REG_A0,
      REG_A1,
      REG_A2,
      REG_A3
   } csr_reg_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
      logic     last;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic ff_more;
      logic fb_none;
      logic fb_more;
      logic div_more;
      logic out_busy;
   } cond_flags_type;

   localparam pc_type PC_WAIT     = 4'd0;
   localparam pc_type PC_FF_MUL   = 4'd1;
   localparam pc_type PC_FF_ACC   = 4'd2;
   localparam pc_type PC_FB_INIT  = 4'd3;
   localparam pc_type PC_FB_MUL   = 4'd4;
   localparam pc_type PC_FB_ACC   = 4'd5;
   localparam pc_type PC_DIV_INIT = 4'd6;
   localparam pc_type PC_DIV      = 4'd7;
   localparam pc_type PC_FINISH   = 4'd8;

   // Control store: a taken condition jumps to target, else fall through
   // (or back to the top after the last word).
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_WAIT:     w = '{OP_START,    COND_NO_REQ,   PC_WAIT,     1'b0};
         PC_FF_MUL:   w = '{OP_MUL_FF,   COND_NEVER,    PC_WAIT,     1'b0};
         PC_FF_ACC:   w = '{OP_ACC_ADD,  COND_FF_MORE,  PC_FF_MUL,   1'b0};
         PC_FB_INIT:  w = '{OP_FB_INIT,  COND_FB_NONE,  PC_DIV_INIT, 1'b0};
         PC_FB_MUL:   w = '{OP_MUL_FB,   COND_NEVER,    PC_WAIT,     1'b0};
         PC_FB_ACC:   w = '{OP_ACC_SUB,  COND_FB_MORE,  PC_FB_MUL,   1'b0};
         PC_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,    PC_WAIT,     1'b0};
         PC_DIV:      w = '{OP_DIV_STEP, COND_DIV_MORE, PC_DIV,      1'b0};
         PC_FINISH:   w = '{OP_FINISH,   COND_OUT_BUSY, PC_FINISH,   1'b1};
         default:     w = '{OP_NOP,      COND_NEVER,    PC_WAIT,     1'b1};
      endcase
      return w;
   endfunction

endpackage

// ===== src/iir_df1_req_if.sv =====
// Input sample channel of the IIR filter.
interface iir_df1_req_if import iir_df1_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// ===== src/iir_df1_rsp_if.sv =====
// Output sample channel of the IIR filter.
interface iir_df1_rsp_if import iir_df1_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== src/iir_filter_direct_form_one.sv =====
// Direct form one IIR filter: CSR bank, shared MAC and divider datapath, sequencer.
//
// One signed 16-bit sample in, one saturated 16-bit sample plus clip flag out.
// y = (sum b_k*x[n-k] - sum a_k*y[n-k]) / a0, quotient truncated toward zero,
// held saturated to 32 bits in the feedback history. A microcoded sequencer
// drives one 18x32 multiplier (multiply, then accumulate, for each tap) and a
// restoring divider that retires two quotient bits per cycle. A new sample is
// taken while the previous result still waits in the output register; the
// block stalls at its last step only if that result is still unclaimed.
// Coefficients are to be written over the APB port only while idle; the block
// itself does not enforce this. An a0 of zero acts as one.
module iir_filter_direct_form_one import iir_df1_pkg::*; #(
   parameter int NUM_TAPS = NUM_TAPS_DEF,
   parameter int DEN_TAPS = DEN_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   iir_df1_req_if.sink           req,
   iir_df1_rsp_if.source         rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IN_IDX_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
   localparam int OUT_IDX_W = (DEN_TAPS > 1) ? $clog2(DEN_TAPS) : 1;
   localparam int FF_TERMS  = (NUM_TAPS < COEF_TAPS) ? NUM_TAPS : COEF_TAPS;
   localparam int FB_TERMS  = ((DEN_TAPS < COEF_TAPS) ? DEN_TAPS : COEF_TAPS) - 1;

   op_type         op;
   cond_flags_type flags;

   logic [COEF_W-1:0]     coef_b_ff [COEF_TAPS];
   logic [COEF_W-1:0]     coef_b_in [COEF_TAPS];
   logic [COEF_W-1:0]     coef_a_ff [COEF_TAPS-1];
   logic [COEF_W-1:0]     coef_a_in [COEF_TAPS-1];
   logic [A0_W-1:0]       coef_a0_ff, coef_a0_in;

   sample_type            in_hist_ff [NUM_TAPS];
   sample_type            in_hist_in [NUM_TAPS];
   logic [HIST_W-1:0]     out_hist_ff [DEN_TAPS];
   logic [HIST_W-1:0]     out_hist_in [DEN_TAPS];
   logic [IN_IDX_W-1:0]   in_slot_ff, in_slot_in, in_idx_ff, in_idx_in;
   logic [OUT_IDX_W-1:0]  out_slot_ff, out_slot_in, out_idx_ff, out_idx_in;
   logic [TAP_W-1:0]      tap_ff, tap_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         quo_ff, quo_in;
   logic [A0_W-1:0]          rem_ff, rem_in, div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            sample_out_ff, sample_out_in;
   logic                  clipped_ff, clipped_in;

   logic                  csr_wr;
   csr_reg_type           csr_idx;
   logic                  out_busy;
   logic [TAP_W-1:0]      a_idx;
   logic signed [COEF_W-1:0] mul_c;
   logic signed [HIST_W-1:0] mul_d;
   sample_type            x_cur;
   logic signed [ACC_W-1:0]  prod_ext;
   logic [A0_W:0]         rs1, rs2, dsub, r1, r2;
   logic                  b1, b2;
   logic signed [ACC_W-1:0]  q_full;
   logic [HIST_W-1:0]     q32;
   logic                  ovf32, ovf16;
   sample_type            q16;

   iir_df1_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   assign csr_wr   = psel & penable & pwrite;
   assign csr_idx  = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready   = 1'b1;
   assign out_busy = rsp_valid_ff & !rsp.ready;

   assign req.ready      = (op == OP_START);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = sample_out_ff;
   assign rsp.clipped    = clipped_ff;

   assign flags.req_valid = req.valid;
   assign flags.ff_more   = (tap_ff != TAP_W'(FF_TERMS - 1));
   assign flags.fb_none   = (FB_TERMS == 0);
   assign flags.fb_more   = (tap_ff != TAP_W'(FB_TERMS));
   assign flags.div_more  = (dcnt_ff != DCNT_W'(DIV_STEPS - 1));
   assign flags.out_busy  = out_busy;

   always_comb begin
      unique case (csr_idx)
         REG_B0: prdata = CSR_DATA_W'(coef_b_ff[0]);
         REG_B1: prdata = CSR_DATA_W'(coef_b_ff[1]);
         REG_B2: prdata = CSR_DATA_W'(coef_b_ff[2]);
         REG_B3: prdata = CSR_DATA_W'(coef_b_ff[3]);
         REG_A0: prdata = CSR_DATA_W'(coef_a0_ff);
         REG_A1: prdata = CSR_DATA_W'(coef_a_ff[0]);
         REG_A2: prdata = CSR_DATA_W'(coef_a_ff[1]);
         REG_A3: prdata = CSR_DATA_W'(coef_a_ff[2]);
      endcase
   end

   // Shared multiplier operands.
   always_comb begin
      a_idx = tap_ff - TAP_W'(1);
      x_cur = in_hist_ff[in_idx_ff];
      if (op == OP_MUL_FB) begin
         mul_c = $signed(coef_a_ff[a_idx]);
         mul_d = $signed(out_hist_ff[out_idx_ff]);
      end else begin
         mul_c = $signed(coef_b_ff[tap_ff]);
         mul_d = {{(HIST_W - SAMPLE_W){x_cur[SAMPLE_W-1]}}, x_cur};
      end
      prod_in  = mul_c * mul_d;
      prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   // Two restoring divide steps on the magnitude.
   always_comb begin
      dsub = {1'b0, div_ff};
      rs1  = {rem_ff, quo_ff[ACC_W-1]};
      b1   = (rs1 >= dsub);
      r1   = b1 ? (rs1 - dsub) : rs1;
      rs2  = {r1[A0_W-1:0], quo_ff[ACC_W-2]};
      b2   = (rs2 >= dsub);
      r2   = b2 ? (rs2 - dsub) : rs2;
   end

   // Sign restore and saturation to 32, then 16 bits.
   always_comb begin
      q_full = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      ovf32  = !((&q_full[ACC_W-1:HIST_W-1]) || !(|q_full[ACC_W-1:HIST_W-1]));
      if (ovf32) begin
         q32 = q_full[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
      end else begin
         q32 = q_full[HIST_W-1:0];
      end
      ovf16 = !((&q32[HIST_W-1:SAMPLE_W-1]) || !(|q32[HIST_W-1:SAMPLE_W-1]));
      if (ovf16) begin
         q16 = q32[HIST_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         q16 = q32[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      coef_b_in     = coef_b_ff;
      coef_a_in     = coef_a_ff;
      coef_a0_in    = coef_a0_ff;
      in_hist_in    = in_hist_ff;
      out_hist_in   = out_hist_ff;
      in_slot_in    = in_slot_ff;
      in_idx_in     = in_idx_ff;
      out_slot_in   = out_slot_ff;
      out_idx_in    = out_idx_ff;
      tap_in        = tap_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      neg_in        = neg_ff;
      dcnt_in       = dcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      sample_out_in = sample_out_ff;
      clipped_in    = clipped_ff;

      if (csr_wr) begin
         unique case (csr_idx)
            REG_B0: coef_b_in[0] = pwdata[COEF_W-1:0];
            REG_B1: coef_b_in[1] = pwdata[COEF_W-1:0];
            REG_B2: coef_b_in[2] = pwdata[COEF_W-1:0];
            REG_B3: coef_b_in[3] = pwdata[COEF_W-1:0];
            REG_A0: coef_a0_in   = pwdata[A0_W-1:0];
            REG_A1: coef_a_in[0] = pwdata[COEF_W-1:0];
            REG_A2: coef_a_in[1] = pwdata[COEF_W-1:0];
            REG_A3: coef_a_in[2] = pwdata[COEF_W-1:0];
         endcase
      end

      // Drop the result once the sink takes it.
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (op)
         OP_NOP: begin
         end
         OP_START: begin
            if (req.valid) begin
               in_hist_in[in_slot_ff] = req.sample_in;
               acc_in    = '0;
               tap_in    = '0;
               in_idx_in = in_slot_ff;
            end
         end
         OP_MUL_FF, OP_MUL_FB: begin
         end
         OP_ACC_ADD: begin
            acc_in    = acc_ff + prod_ext;
            tap_in    = tap_ff + TAP_W'(1);
            in_idx_in = (in_idx_ff == '0) ? IN_IDX_W'(NUM_TAPS - 1) : in_idx_ff - IN_IDX_W'(1);
         end
         OP_FB_INIT: begin
            tap_in     = TAP_W'(1);
            out_idx_in = (out_slot_ff == '0) ? OUT_IDX_W'(DEN_TAPS - 1)
                                             : out_slot_ff - OUT_IDX_W'(1);
         end
         OP_ACC_SUB: begin
            acc_in     = acc_ff - prod_ext;
            tap_in     = tap_ff + TAP_W'(1);
            out_idx_in = (out_idx_ff == '0) ? OUT_IDX_W'(DEN_TAPS - 1)
                                            : out_idx_ff - OUT_IDX_W'(1);
         end
         OP_DIV_INIT: begin
            neg_in  = acc_ff[ACC_W-1];
            quo_in  = acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
            rem_in  = '0;
            dcnt_in = '0;
            div_in  = (coef_a0_ff == '0) ? A0_W'(1) : coef_a0_ff;
         end
         OP_DIV_STEP: begin
            rem_in  = r2[A0_W-1:0];
            quo_in  = {quo_ff[ACC_W-3:0], b1, b2};
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         OP_FINISH: begin
            // Hold everything while the previous result is unclaimed.
            if (!out_busy) begin
               out_hist_in[out_slot_ff] = q32;
               sample_out_in = q16;
               clipped_in    = ovf16;
               rsp_valid_in  = 1'b1;
               in_slot_in    = (in_slot_ff == IN_IDX_W'(NUM_TAPS - 1)) ? '0
                                                                      : in_slot_ff + IN_IDX_W'(1);
               out_slot_in   = (out_slot_ff == OUT_IDX_W'(DEN_TAPS - 1)) ? '0
                                                                        : out_slot_ff + OUT_IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff    <= '{COEF_W'(1), COEF_W'(0), COEF_W'(0), COEF_W'(0)};
         coef_a_ff    <= '{default: '0};
         coef_a0_ff   <= A0_W'(1);
         in_hist_ff   <= '{default: '0};
         out_hist_ff  <= '{default: '0};
         in_slot_ff   <= '0;
         out_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_b_ff    <= coef_b_in;
         coef_a_ff    <= coef_a_in;
         coef_a0_ff   <= coef_a0_in;
         in_hist_ff   <= in_hist_in;
         out_hist_ff  <= out_hist_in;
         in_slot_ff   <= in_slot_in;
         out_slot_ff  <= out_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers: no reset needed.
   always_ff @(posedge clock) begin
      if (op == OP_MUL_FF || op == OP_MUL_FB) begin
         prod_ff <= prod_in;
      end
      in_idx_ff     <= in_idx_in;
      out_idx_ff    <= out_idx_in;
      tap_ff        <= tap_in;
      acc_ff        <= acc_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      neg_ff        <= neg_in;
      dcnt_ff       <= dcnt_in;
      sample_out_ff <= sample_out_in;
      clipped_ff    <= clipped_in;
   end

endmodule

// ===== src/iir_df1_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module iir_df1_seq import iir_df1_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cond_flags_type flags,
   output op_type         op
);

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type uword;
   logic      taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      uword = ucode(pc_ff);
      unique case (uword.cond)
         COND_NEVER:    taken = 1'b0;
         COND_NO_REQ:   taken = !flags.req_valid;
         COND_FF_MORE:  taken = flags.ff_more;
         COND_FB_NONE:  taken = flags.fb_none;
         COND_FB_MORE:  taken = flags.fb_more;
         COND_DIV_MORE: taken = flags.div_more;
         COND_OUT_BUSY: taken = flags.out_busy;
         default:       taken = 1'b0;
      endcase
      if (taken) begin
         pc_in = uword.target;
      end else if (uword.last) begin
         pc_in = PC_WAIT;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
      op = uword.op;
   end

endmodule
